// File: rtl/core/logu_pkg.sv
`default_nettype none
package logu_pkg;

  // default geometry and limits
  localparam int DEF_MAP_WIDTH      = 256;
  localparam int DEF_MAP_HEIGHT     = 256;
  localparam int DEF_MAX_BEAMS      = 1024;
  localparam int DEF_OCC_THRESHOLD  = 512;
  localparam int DEF_FREE_THRESHOLD = -512;
  localparam int DEF_ROBOT_RADIUS   = 77;
  localparam int CELL_W             = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_DELTA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_DELTA  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LO_LIMIT   = 3'd7;

  localparam logic [15:0]        RST_CELL_SIZE  = 16'd13;
  localparam logic signed [15:0] RST_FREE_DELTA = -16'sd102;
  localparam logic signed [15:0] RST_OCC_DELTA  = 16'sd218;
  localparam logic [14:0]        RST_LO_LIMIT   = 15'd1280;

  // range filter in Q8.8
  localparam logic [15:0] RANGE_MIN = 16'd26;
  localparam logic [15:0] RANGE_MAX = 16'd7680;

  localparam logic CMD_RAY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CLASS_FREE    = 2'd0;
  localparam logic [1:0] CLASS_OCC     = 2'd1;
  localparam logic [1:0] CLASS_UNKNOWN = 2'd2;

  // cordic
  localparam int          CORDIC_STEPS = 16;
  localparam logic [19:0] CORDIC_X0    = 20'd19898;

  // address source for the map memory
  localparam logic [1:0] ADDR_CUR = 2'd0;
  localparam logic [1:0] ADDR_END = 2'd1;
  localparam logic [1:0] ADDR_QRY = 2'd2;

  // division order: robot cell then endpoint cell
  localparam logic [1:0] DSEL_X0 = 2'd0;
  localparam logic [1:0] DSEL_Y0 = 2'd1;
  localparam logic [1:0] DSEL_X1 = 2'd2;
  localparam logic [1:0] DSEL_Y1 = 2'd3;

  // world position and cell coordinate widths
  localparam int EP_W  = 26;
  localparam int NUM_W = 27;
  localparam int CRD_W = 28;

  typedef struct packed {
    logic               cmd;
    logic               range_valid;
    logic [15:0]        range;
    logic [9:0]         beam_index;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic [15:0]        robot_heading;
    logic [7:0]         query_x;
    logic [7:0]         query_y;
  } in_item_t;

  typedef struct packed {
    logic               ray_skipped;
    logic               endpoint_marked;
    logic [1:0]         cell_class;
    logic signed [15:0] cell_log_odds;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       cord_init;
    logic       cord_step;
    logic       mul_x;
    logic       mul_y;
    logic       div_start;
    logic [1:0] div_sel;
    logic       bres_init;
    logic       advance;
    logic [1:0] addr_sel;
    logic       mem_rd;
    logic       wr_free;
    logic       wr_occ;
    logic       clr_step;
    logic       res_skip;
    logic       res_mark;
    logic       res_read_hit;
    logic       res_read_miss;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic skip;
    logic q_in_map;
    logic cord_last;
    logic div_done;
    logic at_end;
    logic cur_in_map;
    logic end_ok;
    logic clr_last;
  } dp_sts_t;

  function automatic logic signed [31:0] atan_lut(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:    v = 32'sd536870912;
      4'd1:    v = 32'sd316933406;
      4'd2:    v = 32'sd167458907;
      4'd3:    v = 32'sd85004758;
      4'd4:    v = 32'sd42667330;
      4'd5:    v = 32'sd21354465;
      4'd6:    v = 32'sd10679843;
      4'd7:    v = 32'sd5340245;
      4'd8:    v = 32'sd2670163;
      4'd9:    v = 32'sd1335087;
      4'd10:   v = 32'sd667544;
      4'd11:   v = 32'sd333772;
      4'd12:   v = 32'sd166886;
      4'd13:   v = 32'sd83443;
      4'd14:   v = 32'sd41722;
      default: v = 32'sd20861;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/logu_if.sv
`default_nettype none
interface logu_in_if;
  logic                valid;
  logic                ready;
  logu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface logu_out_if;
  logic                valid;
  logic                ready;
  logu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/log_odds_ray_grid_update.sv
// Log-odds occupancy grid updated by laser rays.
// in_ch carries one word per ray (cmd 0) or per cell read (cmd 1); out_ch
// returns exactly one word for each accepted input word, in order.
// cfg_we/cfg_index/cfg_wdata write the grid registers; write only while idle.
// After reset the map memory is swept to zero, one cell a cycle, over all
// MAP_WIDTH*MAP_HEIGHT cells (65536 by default); in_ch.ready stays low.
// One item is worked at a time; in_ch.ready is high only when the
// controller is idle.
// Ray: setup of 16 CORDIC rotations, two multiplies and four serial
// divisions by the cell size, then a walk along the line in which each
// cell inside the map is read, then written, on the single map port, and
// cells outside it are passed; last the endpoint cell, if marked, is updated.
// A finished word sits in an output register; the next item is accepted
// while it waits, but that item cannot finish until out_ch takes the word.
`default_nettype none
module log_odds_ray_grid_update #(
  parameter int MAP_WIDTH      = logu_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT     = logu_pkg::DEF_MAP_HEIGHT,
  parameter int MAX_BEAMS      = logu_pkg::DEF_MAX_BEAMS,
  parameter int OCC_THRESHOLD  = logu_pkg::DEF_OCC_THRESHOLD,
  parameter int FREE_THRESHOLD = logu_pkg::DEF_FREE_THRESHOLD,
  parameter int ROBOT_RADIUS   = logu_pkg::DEF_ROBOT_RADIUS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  logu_in_if.sink                                in_ch,
  logu_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [logu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [logu_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  logu_pkg::dp_cmd_t cmd;
  logu_pkg::dp_sts_t sts;

  logu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  logu_dp #(
    .MAP_WIDTH      (MAP_WIDTH),
    .MAP_HEIGHT     (MAP_HEIGHT),
    .MAX_BEAMS      (MAX_BEAMS),
    .OCC_THRESHOLD  (OCC_THRESHOLD),
    .FREE_THRESHOLD (FREE_THRESHOLD),
    .ROBOT_RADIUS   (ROBOT_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_ch.data)
  );
endmodule
`default_nettype wire

// File: rtl/core/logu_ram.sv
`default_nettype none
module logu_ram #(
  parameter int WIDTH = logu_pkg::CELL_W,
  parameter int DEPTH = logu_pkg::DEF_MAP_WIDTH * logu_pkg::DEF_MAP_HEIGHT
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/core/logu_div.sv
`default_nettype none
module logu_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [logu_pkg::NUM_W-1:0]     num,
  input  wire logic        [15:0]                    den,
  output logic                                       done,
  output logic signed      [logu_pkg::CRD_W-1:0]     quo
);
  localparam int NW  = logu_pkg::NUM_W;
  localparam int CNW = $clog2(NW);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [15:0]    rem_r;
  logic [15:0]    den_r;
  logic [NW-1:0]  quo_r;
  logic           neg_r;
  logic [17:0]    diff;
  logic           ge;

  // one quotient bit per cycle, restoring
  assign diff = {1'b0, rem_r, quo_r[NW-1]} - {2'b00, den_r};
  assign ge   = !diff[17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= (den == 16'd0) ? 16'd1 : den;
      neg_r <= num[NW-1];
      quo_r <= num[NW-1] ? NW'(-num) : NW'(num);
    end else if (busy_r) begin
      rem_r <= ge ? diff[15:0] : {rem_r[14:0], quo_r[NW-1]};
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
endmodule
`default_nettype wire

// File: rtl/core/logu_dp.sv
`default_nettype none
module logu_dp #(
  parameter int MAP_WIDTH      = logu_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT     = logu_pkg::DEF_MAP_HEIGHT,
  parameter int MAX_BEAMS      = logu_pkg::DEF_MAX_BEAMS,
  parameter int OCC_THRESHOLD  = logu_pkg::DEF_OCC_THRESHOLD,
  parameter int FREE_THRESHOLD = logu_pkg::DEF_FREE_THRESHOLD,
  parameter int ROBOT_RADIUS   = logu_pkg::DEF_ROBOT_RADIUS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [logu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [logu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logu_pkg::in_item_t                   in_data,
  input  wire logu_pkg::dp_cmd_t                    cmd,
  output logu_pkg::dp_sts_t                         sts,
  output logu_pkg::out_item_t                       out_data
);
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  localparam int CW    = logu_pkg::CRD_W;
  localparam int EW    = logu_pkg::EP_W;
  localparam int NW    = logu_pkg::NUM_W;
  localparam int DW    = CW + 1;
  localparam int RW    = CW + 2;

  localparam logic signed [15:0] OCC_TH  = 16'(OCC_THRESHOLD);
  localparam logic signed [15:0] FREE_TH = 16'(FREE_THRESHOLD);

  // configuration registers
  logic [15:0]        cell_size_r;
  logic signed [23:0] org_x_r;
  logic signed [23:0] org_y_r;
  logic [15:0]        ang_start_r;
  logic [15:0]        ang_step_r;
  logic signed [15:0] free_delta_r;
  logic signed [15:0] occ_delta_r;
  logic [14:0]        lo_limit_r;

  // item
  logic               is_read_r;
  logic               skip_r;
  logic [15:0]        range_r;
  logic signed [23:0] rx_r;
  logic signed [23:0] ry_r;
  logic [7:0]         qx_r;
  logic [7:0]         qy_r;
  logic [15:0]        ang_r;
  logic [25:0]        bprod;

  // cordic
  logic signed [19:0] cor_x_r;
  logic signed [19:0] cor_y_r;
  logic signed [31:0] cor_z_r;
  logic               flip_r;
  logic [3:0]         it_r;
  logic signed [19:0] xs;
  logic signed [19:0] ys;
  logic signed [31:0] atan_v;
  logic [15:0]        ang_fold;

  // endpoint
  logic signed [19:0] mul_in;
  logic signed [19:0] mul_v;
  logic signed [36:0] prod;
  logic signed [21:0] off;
  logic signed [EW-1:0] ex_r;
  logic signed [EW-1:0] ey_r;

  // division
  logic signed [NW-1:0] div_num;
  logic                 div_done;
  logic signed [CW-1:0] div_quo;

  // line walk
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic signed [CW-1:0] x1_r;
  logic signed [CW-1:0] y1_r;
  logic signed [DW-1:0] dx_r;
  logic signed [DW-1:0] dy_r;
  logic                 sx_r;
  logic                 sy_r;
  logic signed [RW-1:0] err_r;
  logic signed [DW-1:0] ddx;
  logic signed [DW-1:0] ddy;
  logic signed [DW-1:0] adx;
  logic signed [DW-1:0] ady;
  logic signed [RW:0]   e2;
  logic                 stepx;
  logic                 stepy;

  // memory
  logic [AW-1:0]        clr_r;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic [XW-1:0]        xi;
  logic [YW-1:0]        yi;
  logic [AW-1:0]        map_addr;
  logic [AW-1:0]        mem_addr;
  logic                 mem_en;
  logic                 mem_we;
  logic [15:0]          mem_wdata;
  logic [15:0]          mem_rdata;
  logic signed [15:0]   cell_val;
  logic signed [16:0]   fsum;
  logic signed [16:0]   osum;
  logic signed [15:0]   fsat;
  logic signed [15:0]   osat;
  logic signed [15:0]   lim_pos;
  logic signed [15:0]   lim_neg;
  logic signed [15:0]   v_free;
  logic signed [15:0]   v_occ;
  logic                 free_ok;

  logu_pkg::out_item_t res_r;
  logu_pkg::out_item_t out_r;

  function automatic logic in_map(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y);
    return !x[CW-1] && ($unsigned(x) < CW'(MAP_WIDTH)) &&
           !y[CW-1] && ($unsigned(y) < CW'(MAP_HEIGHT));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r  <= logu_pkg::RST_CELL_SIZE;
      org_x_r      <= '0;
      org_y_r      <= '0;
      ang_start_r  <= '0;
      ang_step_r   <= '0;
      free_delta_r <= logu_pkg::RST_FREE_DELTA;
      occ_delta_r  <= logu_pkg::RST_OCC_DELTA;
      lo_limit_r   <= logu_pkg::RST_LO_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        logu_pkg::REG_CELL_SIZE:  cell_size_r  <= cfg_wdata[15:0];
        logu_pkg::REG_ORIGIN_X:   org_x_r      <= cfg_wdata;
        logu_pkg::REG_ORIGIN_Y:   org_y_r      <= cfg_wdata;
        logu_pkg::REG_ANG_START:  ang_start_r  <= cfg_wdata[15:0];
        logu_pkg::REG_ANG_STEP:   ang_step_r   <= cfg_wdata[15:0];
        logu_pkg::REG_FREE_DELTA: free_delta_r <= cfg_wdata[15:0];
        logu_pkg::REG_OCC_DELTA:  occ_delta_r  <= cfg_wdata[15:0];
        logu_pkg::REG_LO_LIMIT:   lo_limit_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // beam angle wraps modulo one turn
  assign bprod = in_data.beam_index * ang_step_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read_r <= (in_data.cmd == logu_pkg::CMD_READ);
      skip_r    <= !in_data.range_valid || (in_data.range < logu_pkg::RANGE_MIN) ||
                   (in_data.range > logu_pkg::RANGE_MAX) ||
                   (int'(in_data.beam_index) >= MAX_BEAMS);
      range_r   <= in_data.range;
      rx_r      <= in_data.robot_x;
      ry_r      <= in_data.robot_y;
      qx_r      <= in_data.query_x;
      qy_r      <= in_data.query_y;
      ang_r     <= ang_start_r + bprod[15:0] + in_data.robot_heading;
    end
  end

  // fold into [-quarter, quarter) by a half turn
  assign ang_fold = (ang_r[15] ^ ang_r[14]) ? {~ang_r[15], ang_r[14:0]} : ang_r;
  assign xs       = cor_x_r >>> it_r;
  assign ys       = cor_y_r >>> it_r;
  assign atan_v   = logu_pkg::atan_lut(it_r);

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cor_x_r <= logu_pkg::CORDIC_X0;
      cor_y_r <= '0;
      cor_z_r <= {ang_fold, 16'h0000};
      flip_r  <= ang_r[15] ^ ang_r[14];
      it_r    <= '0;
    end else if (cmd.cord_step) begin
      it_r <= it_r + 1'b1;
      if (!cor_z_r[31]) begin
        cor_x_r <= cor_x_r - ys;
        cor_y_r <= cor_y_r + xs;
        cor_z_r <= cor_z_r - atan_v;
      end else begin
        cor_x_r <= cor_x_r + ys;
        cor_y_r <= cor_y_r - xs;
        cor_z_r <= cor_z_r + atan_v;
      end
    end
  end

  // endpoint = robot + floor(range * trig / 2^15)
  assign mul_in = cmd.mul_y ? cor_y_r : cor_x_r;
  assign mul_v  = flip_r ? -mul_in : mul_in;
  assign prod   = $signed({1'b0, range_r}) * mul_v;
  assign off    = prod[36:15];

  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      ex_r <= EW'(rx_r) + EW'(off);
    end
    if (cmd.mul_y) begin
      ey_r <= EW'(ry_r) + EW'(off);
    end
  end

  always_comb begin
    case (cmd.div_sel)
      logu_pkg::DSEL_X0: div_num = NW'(rx_r) - NW'(org_x_r);
      logu_pkg::DSEL_Y0: div_num = NW'(ry_r) - NW'(org_y_r);
      logu_pkg::DSEL_X1: div_num = NW'(ex_r) - NW'(org_x_r);
      default:           div_num = NW'(ey_r) - NW'(org_y_r);
    endcase
  end

  logu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cell_size_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign ddx   = DW'(x1_r) - DW'(cx_r);
  assign ddy   = DW'(y1_r) - DW'(cy_r);
  assign adx   = ddx[DW-1] ? -ddx : ddx;
  assign ady   = ddy[DW-1] ? -ddy : ddy;
  assign e2    = {err_r, 1'b0};
  assign stepx = e2 > -(RW+1)'(dy_r);
  assign stepy = e2 < (RW+1)'(dx_r);

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        logu_pkg::DSEL_X0: cx_r <= div_quo;
        logu_pkg::DSEL_Y0: cy_r <= div_quo;
        logu_pkg::DSEL_X1: x1_r <= div_quo;
        default:           y1_r <= div_quo;
      endcase
    end else if (cmd.bres_init) begin
      dx_r  <= adx;
      dy_r  <= ady;
      sx_r  <= !ddx[DW-1] && (ddx != '0);
      sy_r  <= !ddy[DW-1] && (ddy != '0);
      err_r <= RW'(adx) - RW'(ady);
    end else if (cmd.advance) begin
      err_r <= err_r - (stepx ? RW'(dy_r) : '0) + (stepy ? RW'(dx_r) : '0);
      if (stepx) begin
        cx_r <= sx_r ? cx_r + CW'(1) : cx_r - CW'(1);
      end
      if (stepy) begin
        cy_r <= sy_r ? cy_r + CW'(1) : cy_r - CW'(1);
      end
    end
  end

  // map address
  always_comb begin
    case (cmd.addr_sel)
      logu_pkg::ADDR_CUR: begin
        ax = cx_r;
        ay = cy_r;
      end
      logu_pkg::ADDR_END: begin
        ax = x1_r;
        ay = y1_r;
      end
      default: begin
        ax = CW'(qx_r);
        ay = CW'(qy_r);
      end
    endcase
  end

  assign xi       = ax[XW-1:0];
  assign yi       = ay[YW-1:0];
  assign map_addr = AW'(yi * MAP_WIDTH) + AW'(xi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // cell update arithmetic
  assign cell_val = mem_rdata;
  assign fsum     = 17'(cell_val) + 17'(free_delta_r);
  assign osum     = 17'(cell_val) + 17'(occ_delta_r);
  assign fsat     = (fsum > 17'sd32767) ? 16'sh7fff :
                    (fsum < -17'sd32768) ? 16'sh8000 : fsum[15:0];
  assign osat     = (osum > 17'sd32767) ? 16'sh7fff :
                    (osum < -17'sd32768) ? 16'sh8000 : osum[15:0];
  assign lim_pos  = $signed({1'b0, lo_limit_r});
  assign lim_neg  = -lim_pos;
  assign v_free   = (fsat < lim_neg) ? lim_neg : fsat;
  assign v_occ    = (osat > lim_pos) ? lim_pos : osat;
  assign free_ok  = !free_delta_r[15] || (cell_val < OCC_TH);

  assign mem_we    = cmd.clr_step || cmd.wr_occ || (cmd.wr_free && free_ok);
  assign mem_en    = mem_we || cmd.mem_rd;
  assign mem_addr  = cmd.clr_step ? clr_r : map_addr;
  assign mem_wdata = cmd.clr_step ? 16'h0000 : (cmd.wr_occ ? v_occ : v_free);

  logu_ram #(
    .WIDTH (logu_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= '0;
    end else begin
      if (cmd.res_skip) begin
        res_r.ray_skipped <= 1'b1;
      end
      if (cmd.res_mark) begin
        res_r.endpoint_marked <= 1'b1;
      end
      if (cmd.res_read_hit) begin
        res_r.cell_log_odds <= cell_val;
        res_r.cell_class    <= (cell_val > OCC_TH)  ? logu_pkg::CLASS_OCC :
                               (cell_val < FREE_TH) ? logu_pkg::CLASS_FREE :
                                                      logu_pkg::CLASS_UNKNOWN;
      end
      if (cmd.res_read_miss) begin
        res_r.cell_class <= logu_pkg::CLASS_UNKNOWN;
      end
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  assign sts.is_read    = is_read_r;
  assign sts.skip       = skip_r;
  assign sts.q_in_map   = (int'(qx_r) < MAP_WIDTH) && (int'(qy_r) < MAP_HEIGHT);
  assign sts.cord_last  = (it_r == 4'(logu_pkg::CORDIC_STEPS - 1));
  assign sts.div_done   = div_done;
  assign sts.at_end     = (cx_r == x1_r) && (cy_r == y1_r);
  assign sts.cur_in_map = in_map(cx_r, cy_r);
  assign sts.end_ok     = in_map(x1_r, y1_r) && (int'(range_r) > ROBOT_RADIUS);
  assign sts.clr_last   = (clr_r == AW'(DEPTH - 1));
endmodule
`default_nettype wire

// File: rtl/core/logu_ctrl.sv
`default_nettype none
module logu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logu_pkg::dp_sts_t sts,
  output logu_pkg::dp_cmd_t      cmd
);
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_RD_WAIT  = 4'd3;
  localparam logic [3:0] S_CORD     = 4'd4;
  localparam logic [3:0] S_MULX     = 4'd5;
  localparam logic [3:0] S_MULY     = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_BRES     = 4'd9;
  localparam logic [3:0] S_WALK     = 4'd10;
  localparam logic [3:0] S_WALK_UPD = 4'd11;
  localparam logic [3:0] S_END      = 4'd12;
  localparam logic [3:0] S_END_UPD  = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [1:0] dsel_r;
  logic [1:0] dsel_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd         = '0;
    cmd.div_sel = dsel_r;
    state_nxt   = state_r;
    dsel_nxt    = dsel_r;
    in_ready    = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_read) begin
          if (sts.q_in_map) begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = logu_pkg::ADDR_QRY;
            state_nxt    = S_RD_WAIT;
          end else begin
            cmd.res_read_miss = 1'b1;
            state_nxt         = S_DONE;
          end
        end else if (sts.skip) begin
          cmd.res_skip = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.cord_init = 1'b1;
          state_nxt     = S_CORD;
        end
      end
      S_RD_WAIT: begin
        cmd.res_read_hit = 1'b1;
        state_nxt        = S_DONE;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        dsel_nxt  = logu_pkg::DSEL_X0;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (dsel_r == logu_pkg::DSEL_Y1) begin
            state_nxt = S_BRES;
          end else begin
            dsel_nxt  = dsel_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_BRES: begin
        cmd.bres_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.addr_sel = logu_pkg::ADDR_CUR;
        if (sts.at_end) begin
          state_nxt = S_END;
        end else if (sts.cur_in_map) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_WALK_UPD;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_WALK_UPD: begin
        cmd.addr_sel = logu_pkg::ADDR_CUR;
        cmd.wr_free  = 1'b1;
        cmd.advance  = 1'b1;
        state_nxt    = S_WALK;
      end
      S_END: begin
        cmd.addr_sel = logu_pkg::ADDR_END;
        if (sts.end_ok) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_END_UPD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_END_UPD: begin
        cmd.addr_sel = logu_pkg::ADDR_END;
        cmd.wr_occ   = 1'b1;
        cmd.res_mark = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dsel_r      <= logu_pkg::DSEL_X0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: verif/grid_mirror.sv
`timescale 1ns / 100ps
module grid_mirror (
  input  logic                             clk,
  input  logic                             rst_n,
  logu_in_if                               in_ch,
  logu_out_if                              out_ch,
  input  logic                             cfg_we,
  input  logic [logu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [logu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               words_due
);
  import logu_pkg::*;

  localparam int GRID_W      = 256;
  localparam int GRID_H      = 256;
  localparam int OCC_LEVEL   = 512;
  localparam int FREE_LEVEL  = -512;
  localparam int BODY_RADIUS = 77;

  // rotation angles in units of 2^32 per turn
  localparam longint ROT_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004758, 42667330, 21354465,
    10679843, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  logic signed [15:0] grid [GRID_W*GRID_H];
  logic [15:0]        res_q88;
  logic signed [23:0] org_x, org_y;
  logic [15:0]        beam_base;
  logic signed [15:0] beam_step, free_step, hit_step;
  logic [14:0]        clamp_mag;
  out_item_t          due_q [$];

  initial fail_count = 0;

  function automatic bit on_grid(longint x, longint y);
    return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
  endfunction

  function automatic void lower_cell(longint x, longint y);
    longint v;
    int     idx;
    if (!on_grid(x, y)) return;
    idx = int'(x + y * GRID_W);
    if (free_step >= 0 || grid[idx] < OCC_LEVEL) begin
      v = longint'(grid[idx]) + longint'(free_step);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (v < -longint'(clamp_mag)) v = -longint'(clamp_mag);
      grid[idx] = v[15:0];
    end
  endfunction

  function automatic longint world_to_cell(longint w, longint origin);
    longint d;
    d = (res_q88 == 0) ? 1 : longint'(res_q88);
    return (w - origin) / d;
  endfunction

  function automatic out_item_t trace_ray(in_item_t it);
    out_item_t r;
    logic [15:0] ang;
    longint a, x, y, z, xs, ys, c, s, ex, ey;
    longint x0, y0, x1, y1, dx, dy, sx, sy, err, e2, v;
    bit flip;
    int idx;
    r = '0;
    if (!it.range_valid || it.range < 26 || it.range > 7680) begin
      r.ray_skipped = 1'b1;
      return r;
    end
    ang = beam_base + it.beam_index * beam_step + it.robot_heading;
    a = longint'(ang);
    flip = 0;
    if (a >= 16384 && a < 49152) begin
      a -= 32768;
      flip = 1;
    end else if (a >= 49152) begin
      a -= 65536;
    end
    z = a * 65536;
    x = 19898;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ROT_ANGLE[i];
      end else begin
        x += ys; y -= xs; z += ROT_ANGLE[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    ex = longint'(it.robot_x) + ((longint'(it.range) * c) >>> 15);
    ey = longint'(it.robot_y) + ((longint'(it.range) * s) >>> 15);
    x0 = world_to_cell(longint'(it.robot_x), longint'(org_x));
    y0 = world_to_cell(longint'(it.robot_y), longint'(org_y));
    x1 = world_to_cell(ex, longint'(org_x));
    y1 = world_to_cell(ey, longint'(org_y));
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    while (!(x0 == x1 && y0 == y1)) begin
      lower_cell(x0, y0);
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x0 += sx; end
      if (e2 < dx) begin err += dx; y0 += sy; end
    end
    if (on_grid(x1, y1) && it.range > BODY_RADIUS) begin
      idx = int'(x1 + y1 * GRID_W);
      v = longint'(grid[idx]) + longint'(hit_step);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (v > longint'(clamp_mag)) v = longint'(clamp_mag);
      grid[idx] = v[15:0];
      r.endpoint_marked = 1'b1;
    end
    return r;
  endfunction

  function automatic out_item_t read_cell(in_item_t it);
    out_item_t r;
    logic signed [15:0] l;
    r = '0;
    l = grid[int'(it.query_x) + int'(it.query_y) * GRID_W];
    r.cell_log_odds = l;
    if (l > OCC_LEVEL) r.cell_class = CLASS_OCC;
    else if (l < FREE_LEVEL) r.cell_class = CLASS_FREE;
    else r.cell_class = CLASS_UNKNOWN;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    out_item_t want;
    if (!rst_n) begin
      res_q88   <= RST_CELL_SIZE;
      org_x     <= '0;
      org_y     <= '0;
      beam_base <= '0;
      beam_step <= '0;
      free_step <= RST_FREE_DELTA;
      hit_step  <= RST_OCC_DELTA;
      clamp_mag <= RST_LO_LIMIT;
      foreach (grid[i]) grid[i] = '0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_SIZE:  res_q88   <= cfg_wdata[15:0];
          REG_ORIGIN_X:   org_x     <= cfg_wdata;
          REG_ORIGIN_Y:   org_y     <= cfg_wdata;
          REG_ANG_START:  beam_base <= cfg_wdata[15:0];
          REG_ANG_STEP:   beam_step <= cfg_wdata[15:0];
          REG_FREE_DELTA: free_step <= cfg_wdata[15:0];
          REG_OCC_DELTA:  hit_step  <= cfg_wdata[15:0];
          REG_LO_LIMIT:   clamp_mag <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        w = out_ch.data;
        if (due_q.size() == 0) begin
          report("word with nothing expected", 1, 0);
        end else begin
          want = due_q.pop_front();
          if (w.ray_skipped !== want.ray_skipped)
            report("ray_skipped", w.ray_skipped, want.ray_skipped);
          if (w.endpoint_marked !== want.endpoint_marked)
            report("endpoint_marked", w.endpoint_marked, want.endpoint_marked);
          if (w.cell_class !== want.cell_class)
            report("cell_class", w.cell_class, want.cell_class);
          if (w.cell_log_odds !== want.cell_log_odds)
            report("cell_log_odds", w.cell_log_odds, want.cell_log_odds);
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_q.push_back(in_ch.data.cmd == CMD_READ ? read_cell(in_ch.data)
                                                   : trace_ray(in_ch.data));
    end
    words_due <= due_q.size();
  end
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import logu_pkg::*;

  localparam longint CYCLE_LIMIT = 12_000_000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count;
  int words_due;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  longint cycles;
  int last_cx, last_cy;

  logu_in_if  in_ch ();
  logu_out_if out_ch ();

  log_odds_ray_grid_update u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  grid_mirror u_mirror (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [15:0] cs, logic [23:0] ox, logic [23:0] oy,
                          logic [15:0] a0, logic [15:0] da, logic [15:0] fd,
                          logic [15:0] od, logic [14:0] lim);
    drain();
    write_reg(REG_CELL_SIZE, {8'd0, cs});
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ANG_START, {8'd0, a0});
    write_reg(REG_ANG_STEP, {8'd0, da});
    write_reg(REG_FREE_DELTA, {8'd0, fd});
    write_reg(REG_OCC_DELTA, {8'd0, od});
    write_reg(REG_LO_LIMIT, {9'd0, lim});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t ray_item(logic vld, logic [15:0] rng, logic [9:0] beam,
                                        logic [23:0] x, logic [23:0] y, logic [15:0] hd);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.cmd           = CMD_RAY;
    it.range_valid   = vld;
    it.range         = rng;
    it.beam_index    = beam;
    it.robot_x       = x;
    it.robot_y       = y;
    it.robot_heading = hd;
    return it;
  endfunction

  function automatic in_item_t read_item(logic [7:0] qx, logic [7:0] qy);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.cmd     = CMD_READ;
    it.query_x = qx;
    it.query_y = qy;
    return it;
  endfunction

  // rounds of scans, each from one pose, with 1 to 5 reads mostly around it
  task automatic run_phase(int n, int rmax, int cs, longint ox, longint oy, int mode);
    int sent, nb, nr, roll, cse, beam, cx, cy;
    logic [15:0] hd, rng;
    logic vld;
    longint rx, ry;
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
    cse = (cs == 0) ? 1 : cs;
    sent = 0;
    cx = 128;
    cy = 128;
    while (sent < n) begin
      if ($urandom_range(99) >= 30) begin
        cx = $urandom_range(0, 265) - 5;
        cy = $urandom_range(0, 265) - 5;
      end
      rx = ox + longint'(cx) * cse + $urandom_range(0, cse - 1);
      ry = oy + longint'(cy) * cse + $urandom_range(0, cse - 1);
      if ($urandom_range(99) < 10) begin
        rx = $urandom;
        ry = $urandom;
      end
      hd = $urandom;
      beam = $urandom_range(0, 1023);
      nb = $urandom_range(3, 10);
      for (int k = 0; k < nb; k++) begin
        roll = $urandom_range(99);
        vld = 1'b1;
        rng = $urandom_range(26, rmax);
        if (roll < 3) vld = 1'b0;
        else if (roll < 5) rng = $urandom_range(0, 25);
        else if (roll < 7) rng = $urandom_range(7681, 65535);
        else if (roll < 9) rng = $urandom_range(70, 85);
        else if (roll < 10) begin
          vld = $urandom;
          rng = $urandom;
          if (rng > 7680 && rmax < 7680) vld = 1'b0;
        end
        if (vld && rng >= 26 && rng <= 7680 && rng > rmax) rng = rmax;
        offer(ray_item(vld, rng, beam[9:0], rx[23:0], ry[23:0], hd));
        beam += $urandom_range(1, 40);
      end
      nr = $urandom_range(1, 5);
      for (int k = 0; k < nr; k++) begin
        if ($urandom_range(99) < 60)
          offer(read_item(8'(cx + $urandom_range(0, 8) - 4), 8'(cy + $urandom_range(0, 8) - 4)));
        else
          offer(read_item($urandom, $urandom));
      end
      sent += nb + nr;
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings (0.05 m cells, pose near grid center)
    offer(read_item(8'd0, 8'd0));
    offer(read_item(8'd255, 8'd255));
    offer(ray_item(1'b0, 16'd1000, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd25, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd26, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd7680, 10'd0, 24'd1664, 24'd1664, 16'd100));
    offer(ray_item(1'b1, 16'd7681, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd0, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd65535, 10'd1023, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd77, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd78, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(ray_item(1'b1, 16'd2000, 10'd1023, 24'd1664, 24'd1664, 16'd16384));
    offer(ray_item(1'b1, 16'd2000, 10'd0, 24'd1664, 24'd1664, 16'd32768));
    offer(ray_item(1'b1, 16'd2000, 10'd0, 24'd1664, 24'd1664, 16'd49152));
    offer(ray_item(1'b1, 16'd2000, 10'd0, 24'd1664, 24'd1664, 16'd65535));
    // same ray until the endpoint saturates and the path turns free
    repeat (7) offer(ray_item(1'b1, 16'd1000, 10'd0, 24'd1664, 24'd1664, 16'd0));
    offer(read_item(8'd204, 8'd128));
    offer(read_item(8'd150, 8'd128));
    offer(ray_item(1'b1, 16'd500, 10'd512, 24'h800000, 24'h7fffff, 16'd8192));
    drain();

    // long hold-off on the result side while items keep coming
    hold_req = 1;
    set_grid(16'd13, 24'd0, 24'd0, 16'd0, 16'd64, -16'sd102, 16'sd218, 15'd1280);
    run_phase(260, 7680, 13, 0, 0, 1);
    set_grid(16'd64, -24'sd2560, -24'sd2560, 16'd16384, -16'sd300, -16'sd400,
             16'sd600, 15'd32767);
    run_phase(260, 7680, 64, -2560, -2560, 2);
    set_grid(16'd0, 24'd0, 24'd0, 16'hffff, 16'sd32767, 16'sd32767, -16'sd32768, 15'd0);
    run_phase(200, 200, 0, 0, 0, 3);
    set_grid(16'hffff, 24'h800000, 24'h7fffff, 16'd0, -16'sd32768, -16'sd32768,
             16'sd32767, 15'd20000);
    run_phase(240, 7680, 65535, -8388608, 8388607, 0);
    set_grid(16'd40, 24'd1000, -24'sd3000, 16'd1234, 16'sd17, -16'sd200, 16'sd300, 15'd700);
    run_phase(280, 2500, 40, 1000, -3000, 1);
    set_grid(16'd200, 24'd0, 24'd0, 16'd40000, 16'sd5, 16'sd50, 16'sd100, 15'd32767);
    run_phase(280, 7680, 200, 0, 0, 2);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
